[rtl/rcvc_pkg.sv]
package rcvc_pkg;

    localparam int CODE_W      = 3;
    localparam int NUM_COLORS  = 8;
    localparam int REF_W       = 16;
    localparam int VOTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CODE_W-1:0] COLOR_WHITE = 3'd7;
    localparam logic [VOTE_W-1:0] VOTE_MAX    = 8'd255;
    localparam logic [VOTE_W-1:0] VOTES_RESET = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_REF_RED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_GREEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_BLUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_CLEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOTES_NEEDED = 3'd4;

    typedef struct packed {
        logic [REF_W-1:0] ref_red;
        logic [REF_W-1:0] ref_green;
        logic [REF_W-1:0] ref_blue;
        logic [REF_W-1:0] ref_clear;
    } ref_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } code_item_t;

endpackage

[rtl/rgb_color_vote_classifier_unit.sv]
// A sample that decides a result passes through the product stage register, the code queue
// and the output register. Throughput: one sample per cycle while in_stall is low; the product
// stage and a four-entry code queue hold samples while the output register is stalled.
// Reset clears the vote counters, the queue and all valid flags, sets every reference
// to zero and sets votes_needed to ten.
module rgb_color_vote_classifier_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rcvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcvc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     red_count,
    input  logic [15:0]                     green_count,
    input  logic [15:0]                     blue_count,
    input  logic [15:0]                     clear_count,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      color_code
);

    rcvc_pkg::ref_cfg_t            cfg_reg;
    logic [rcvc_pkg::VOTE_W-1:0]   votes_needed_reg;
    rcvc_pkg::code_item_t          push;
    rcvc_pkg::code_item_t          head;
    logic                          pop;
    logic [rcvc_pkg::QCNT_W-1:0]   queue_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg          <= '0;
            votes_needed_reg <= rcvc_pkg::VOTES_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rcvc_pkg::REG_REF_RED:      cfg_reg.ref_red   <= cfg_data;
                rcvc_pkg::REG_REF_GREEN:    cfg_reg.ref_green <= cfg_data;
                rcvc_pkg::REG_REF_BLUE:     cfg_reg.ref_blue  <= cfg_data;
                rcvc_pkg::REG_REF_CLEAR:    cfg_reg.ref_clear <= cfg_data;
                rcvc_pkg::REG_VOTES_NEEDED: votes_needed_reg  <= cfg_data[rcvc_pkg::VOTE_W-1:0];
                default: ;
            endcase
        end
    end

    rcvc_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_count  (red_count),
        .green_count(green_count),
        .blue_count (blue_count),
        .clear_count(clear_count),
        .queue_count(queue_count),
        .push       (push)
    );

    rcvc_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .pop  (pop),
        .head (head),
        .count(queue_count)
    );

    rcvc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .votes_needed(votes_needed_reg),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_code  (color_code)
    );

endmodule

[rtl/rcvc_front.sv]
module rcvc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcvc_pkg::ref_cfg_t            cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [15:0]                   red_count,
    input  logic [15:0]                   green_count,
    input  logic [15:0]                   blue_count,
    input  logic [15:0]                   clear_count,
    input  logic [rcvc_pkg::QCNT_W-1:0]   queue_count,
    output rcvc_pkg::code_item_t          push
);

    localparam int PX_W = SAMPLE_BITS + rcvc_pkg::REF_W;
    localparam int PY_W = SAMPLE_BITS + rcvc_pkg::REF_W + 1;
    localparam int OCC_W = rcvc_pkg::QCNT_W + 1;

    logic [SAMPLE_BITS-1:0] red_s;
    logic [SAMPLE_BITS-1:0] green_s;
    logic [SAMPLE_BITS-1:0] blue_s;
    logic [SAMPLE_BITS-1:0] clear_s;

    logic            valid_reg;
    logic            valid_next;
    logic            zero_reg;
    logic [PX_W-1:0] rx_reg;
    logic [PX_W-1:0] gx_reg;
    logic [PX_W-1:0] bx_reg;
    logic [PY_W-1:0] ry_reg;
    logic [PY_W-1:0] gy_reg;
    logic [PY_W-1:0] by_reg;
    logic [OCC_W-1:0] occupancy;
    logic            accept;

    assign red_s   = red_count[SAMPLE_BITS-1:0];
    assign green_s = green_count[SAMPLE_BITS-1:0];
    assign blue_s  = blue_count[SAMPLE_BITS-1:0];
    assign clear_s = clear_count[SAMPLE_BITS-1:0];

    // Items in the product stage count against queue space so that the stage never waits.
    assign occupancy = OCC_W'(queue_count) + OCC_W'(valid_reg);
    assign in_stall  = (occupancy >= OCC_W'(rcvc_pkg::QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zero_reg <= (clear_s == '0);
            rx_reg <= PX_W'(red_s) * PX_W'(cfg.ref_clear);
            gx_reg <= PX_W'(green_s) * PX_W'(cfg.ref_clear);
            bx_reg <= PX_W'(blue_s) * PX_W'(cfg.ref_clear);
            ry_reg <= (PY_W'(cfg.ref_red) + PY_W'(1)) * PY_W'(clear_s);
            gy_reg <= (PY_W'(cfg.ref_green) + PY_W'(1)) * PY_W'(clear_s);
            by_reg <= (PY_W'(cfg.ref_blue) + PY_W'(1)) * PY_W'(clear_s);
        end
    end

    always_comb
    begin
        push.valid = valid_reg;
        if (zero_reg)
        begin
            push.code = rcvc_pkg::COLOR_WHITE;
        end
        else
        begin
            push.code[0] = (PY_W'(rx_reg) >= ry_reg);
            push.code[1] = (PY_W'(gx_reg) >= gy_reg);
            push.code[2] = (PY_W'(bx_reg) >= by_reg);
        end
    end

endmodule

[rtl/rcvc_queue.sv]
module rcvc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcvc_pkg::code_item_t        push,
    input  logic                        pop,
    output rcvc_pkg::code_item_t        head,
    output logic [rcvc_pkg::QCNT_W-1:0] count
);

    logic [rcvc_pkg::CODE_W-1:0] slot_reg [rcvc_pkg::QUEUE_DEPTH];
    logic [rcvc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rcvc_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [rcvc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [rcvc_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [rcvc_pkg::QCNT_W-1:0] count_reg;
    logic [rcvc_pkg::QCNT_W-1:0] count_next;
    logic                        do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign wr_ptr_next = push.valid ? wr_ptr_reg + rcvc_pkg::QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + rcvc_pkg::QPTR_W'(1) : rd_ptr_reg;
    assign count_next  = count_reg + rcvc_pkg::QCNT_W'(push.valid)
                         - rcvc_pkg::QCNT_W'(do_pop);

    assign head.valid = (count_reg != '0);
    assign head.code  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.code;
        end
    end

endmodule

[rtl/rcvc_back.sv]
module rcvc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rcvc_pkg::VOTE_W-1:0] votes_needed,
    input  rcvc_pkg::code_item_t        head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rcvc_pkg::CODE_W-1:0] color_code
);

    logic [rcvc_pkg::VOTE_W-1:0] vote_reg [rcvc_pkg::NUM_COLORS];
    logic [rcvc_pkg::VOTE_W-1:0] cur_vote;
    logic [rcvc_pkg::VOTE_W-1:0] new_vote;
    logic                        decide;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rcvc_pkg::CODE_W-1:0] color_reg;

    assign pop      = head.valid && (!out_valid_reg || !out_stall);
    assign cur_vote = vote_reg[head.code];
    assign new_vote = (cur_vote == rcvc_pkg::VOTE_MAX) ? cur_vote
                                                       : cur_vote + rcvc_pkg::VOTE_W'(1);
    assign decide   = (new_vote >= votes_needed);

    always_comb
    begin
        if (pop && decide)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < rcvc_pkg::NUM_COLORS; i++)
            begin
                vote_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (decide)
                begin
                    for (int i = 0; i < rcvc_pkg::NUM_COLORS; i++)
                    begin
                        vote_reg[i] <= '0;
                    end
                end
                else
                begin
                    vote_reg[head.code] <= new_vote;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && decide)
        begin
            color_reg <= head.code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign color_code = color_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [rcvc_pkg::CODE_W-1:0]    COLOR_BLACK = 3'd0;
    localparam logic [rcvc_pkg::CFG_IDX_W-1:0] REG_SPARE_0 = 3'd5;
    localparam logic [rcvc_pkg::CFG_IDX_W-1:0] REG_SPARE_1 = 3'd6;
    localparam logic [rcvc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [rcvc_pkg::CFG_IDX_W-1:0]   idx;
        logic [rcvc_pkg::CFG_DATA_W-1:0]  data;
        logic [15:0]                      r;
        logic [15:0]                      g;
        logic [15:0]                      b;
        logic [15:0]                      c;
        bit                               typed;
        logic [rcvc_pkg::CODE_W-1:0]      code;
    } plan_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [rcvc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rcvc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [15:0]                     red_count;
    logic [15:0]                     green_count;
    logic [15:0]                     blue_count;
    logic [15:0]                     clear_count;
    logic                            out_valid;
    logic                            out_stall;
    logic [2:0]                      color_code;

    logic [15:0]                 cal_red;
    logic [15:0]                 cal_green;
    logic [15:0]                 cal_blue;
    logic [15:0]                 cal_clear;
    logic [7:0]                  votes_to_win;
    logic [7:0]                  tally [rcvc_pkg::NUM_COLORS];
    logic [rcvc_pkg::CODE_W-1:0] color_q [$];
    plan_row_t                   plan [$];

    int unsigned cycles = 0;
    int          errors = 0;
    bit          gaps_on = 1'b1;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    rgb_color_vote_classifier_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red_count   (red_count),
        .green_count (green_count),
        .blue_count  (blue_count),
        .clear_count (clear_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_code  (color_code)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic bit channel_over(logic [15:0] x, logic [15:0] rx, logic [15:0] c);
        logic [33:0] lhs;
        logic [33:0] rhs;
        lhs = {18'd0, x} * {18'd0, cal_clear};
        rhs = ({18'd0, rx} + 34'd1) * {18'd0, c};
        return lhs >= rhs;
    endfunction

    function automatic logic [rcvc_pkg::CODE_W-1:0] color_of(logic [15:0] r, logic [15:0] g,
                                                             logic [15:0] b, logic [15:0] c);
        if (c == 16'd0)
        begin
            return rcvc_pkg::COLOR_WHITE;
        end
        return {channel_over(b, cal_blue, c), channel_over(g, cal_green, c),
                channel_over(r, cal_red, c)};
    endfunction

    task automatic tally_vote(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic [15:0] c,
                              output bit decided,
                              output logic [rcvc_pkg::CODE_W-1:0] code);
        logic [8:0] cnt;
        code = color_of(r, g, b, c);
        cnt = {1'b0, tally[code]} + 9'd1;
        if (cnt > 9'd255)
        begin
            cnt = 9'd255;
        end
        tally[code] = cnt[7:0];
        decided = (cnt >= {1'b0, votes_to_win});
        if (decided)
        begin
            foreach (tally[i])
            begin
                tally[i] = '0;
            end
        end
    endtask

    // A channel value that sits on or just below its decision threshold.
    function automatic logic [15:0] near_threshold(logic [15:0] rx, logic [15:0] c);
        logic [33:0] num;
        logic [33:0] x;
        if (cal_clear == 16'd0)
        begin
            return 16'($urandom);
        end
        num = ({18'd0, rx} + 34'd1) * {18'd0, c};
        x = (num + {18'd0, cal_clear} - 34'd1) / {18'd0, cal_clear};
        if (x > 34'hFFFF)
        begin
            x = 34'hFFFF;
        end
        if (x != 34'd0 && $urandom_range(0, 1) == 1)
        begin
            x = x - 34'd1;
        end
        return x[15:0];
    endfunction

    function automatic logic [15:0] pick_ref();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic make_sample(output logic [15:0] r, output logic [15:0] g,
                               output logic [15:0] b, output logic [15:0] c);
        int mode;
        mode = $urandom_range(0, 9);
        r = 16'($urandom);
        g = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        if (mode == 0)
        begin
            c = 16'd0;
        end
        else if (mode == 1)
        begin
            r = {16{r[0]}};
            g = {16{g[0]}};
            b = {16{b[0]}};
            c = c[0] ? 16'hFFFF : 16'h0001;
        end
        else if (mode <= 4)
        begin
            if (c == 16'd0)
            begin
                c = 16'd1;
            end
            r = near_threshold(cal_red, c);
            g = near_threshold(cal_green, c);
            b = near_threshold(cal_blue, c);
        end
    endtask

    task automatic write_reg(input logic [rcvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcvc_pkg::CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (color_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rcvc_pkg::REG_REF_RED:      cal_red = data;
            rcvc_pkg::REG_REF_GREEN:    cal_green = data;
            rcvc_pkg::REG_REF_BLUE:     cal_blue = data;
            rcvc_pkg::REG_REF_CLEAR:    cal_clear = data;
            rcvc_pkg::REG_VOTES_NEEDED: votes_to_win = data[7:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic [15:0] c,
                             input bit typed, input logic [rcvc_pkg::CODE_W-1:0] typed_code);
        bit                          decided;
        logic [rcvc_pkg::CODE_W-1:0] code;
        if (gaps_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        red_count   <= r;
        green_count <= g;
        blue_count  <= b;
        clear_count <= c;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tally_vote(r, g, b, c, decided, code);
        if (typed)
        begin
            decided = 1'b1;
            code = typed_code;
        end
        if (decided)
        begin
            color_q.push_back(code);
        end
        @(negedge clk);
    endtask

    task automatic add_sample(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic [15:0] c,
                              input bit typed = 1'b0,
                              input logic [rcvc_pkg::CODE_W-1:0] code = COLOR_BLACK);
        plan_row_t row;
        row.kind = ROW_SAMPLE;
        row.idx = '0;
        row.data = '0;
        row.r = r;
        row.g = g;
        row.b = b;
        row.c = c;
        row.typed = typed;
        row.code = code;
        plan.push_back(row);
    endtask

    task automatic add_write(input logic [rcvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcvc_pkg::CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.data = data;
        row.r = '0;
        row.g = '0;
        row.b = '0;
        row.c = '0;
        row.typed = 1'b0;
        row.code = COLOR_BLACK;
        plan.push_back(row);
    endtask

    always @(posedge clk)
    begin
        logic [rcvc_pkg::CODE_W-1:0] want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (color_q.size() == 0)
            begin
                $display("%0t: color_code expected none actual %0d", $time, color_code);
                errors++;
            end
            else
            begin
                want = color_q.pop_front();
                if (color_code !== want)
                begin
                    $display("%0t: color_code expected %0d actual %0d", $time, want, color_code);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 16);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 16);
            end
            repeat (n) @(negedge clk);
        end
    end

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
        end
        $display("FAIL rgb_color_vote_classifier_unit");
        $finish;
    end

    initial
    begin
        int          ph_votes [7];
        int          ph_items [7];
        int          ph_fav   [7];
        logic [15:0] fr, fg, fb, fc;
        logic [15:0] r, g, b, c;

        ph_votes = '{1, 3, 255, 0, 5, -1, 2};
        ph_items = '{100, 120, 280, 60, 120, 100, 80};
        ph_fav   = '{30, 50, 95, 20, 60, 50, 40};

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        red_count   = '0;
        green_count = '0;
        blue_count  = '0;
        clear_count = '0;
        cal_red      = '0;
        cal_green    = '0;
        cal_blue     = '0;
        cal_clear    = '0;
        votes_to_win = rcvc_pkg::VOTES_RESET;
        foreach (tally[i])
        begin
            tally[i] = '0;
        end

        // Reset values: zero references classify every sample black, a zero
        // clear count gives white, and ten equal votes decide.
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h0000);
        add_sample(16'h5555, 16'hAAAA, 16'h5555, 16'h0000);
        add_sample(16'h0001, 16'h0002, 16'h0004, 16'h0000);
        add_sample(16'h8000, 16'h4000, 16'h2000, 16'h0000);
        add_sample(16'h1234, 16'h5678, 16'h9ABC, 16'h0000);
        add_sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        add_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1, rcvc_pkg::COLOR_WHITE);
        add_sample(16'h0001, 16'h0002, 16'h0003, 16'hFFFF);
        // These rows cover the widest products, exact thresholds, unused indexes
        // and upper data bits.
        add_write(rcvc_pkg::REG_REF_RED, 16'hFFFF);
        add_write(rcvc_pkg::REG_REF_GREEN, 16'h0000);
        add_write(rcvc_pkg::REG_REF_BLUE, 16'h8000);
        add_write(rcvc_pkg::REG_REF_CLEAR, 16'hFFFF);
        add_write(rcvc_pkg::REG_VOTES_NEEDED, 16'hFF01);
        add_write(REG_SPARE_0, 16'hFFFF);
        add_write(REG_SPARE_1, 16'h1234);
        add_write(REG_SPARE_2, 16'hFFFF);
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, COLOR_BLACK);
        add_sample(16'h0000, 16'h0000, 16'h8001, 16'hFFFF);
        add_sample(16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
        add_sample(16'h0000, 16'h0001, 16'h0000, 16'h0001);
        add_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, rcvc_pkg::COLOR_WHITE);
        // A zero vote threshold acts like one.
        add_write(rcvc_pkg::REG_VOTES_NEEDED, 16'h0000);
        add_sample(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        add_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, rcvc_pkg::COLOR_WHITE);
        add_write(rcvc_pkg::REG_VOTES_NEEDED, 16'h0002);
        add_sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        add_sample(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_item(plan[i].r, plan[i].g, plan[i].b, plan[i].c,
                          plan[i].typed, plan[i].code);
            end
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(rcvc_pkg::REG_REF_RED, pick_ref());
            write_reg(rcvc_pkg::REG_REF_GREEN, pick_ref());
            write_reg(rcvc_pkg::REG_REF_BLUE, pick_ref());
            write_reg(rcvc_pkg::REG_REF_CLEAR, pick_ref());
            write_reg(rcvc_pkg::REG_VOTES_NEEDED,
                      (ph_votes[ph] < 0) ? 16'($urandom_range(1, 20)) : 16'(ph_votes[ph]));
            quiet = (ph == 6);
            gaps_on = (ph != 4);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            make_sample(fr, fg, fb, fc);
            for (int k = 0; k < ph_items[ph]; k++)
            begin
                if (ph == 5 && k == ph_items[ph] / 2)
                begin
                    in_valid <= 1'b0;
                    while (color_q.size() != 0)
                    begin
                        @(negedge clk);
                    end
                    @(negedge clk);
                end
                if ($urandom_range(0, 99) < ph_fav[ph])
                begin
                    send_item(fr, fg, fb, fc, 1'b0, COLOR_BLACK);
                end
                else
                begin
                    make_sample(r, g, b, c);
                    send_item(r, g, b, c, 1'b0, COLOR_BLACK);
                end
            end
        end

        in_valid <= 1'b0;
        while (color_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (errors == 0)
        begin
            $display("PASS rgb_color_vote_classifier_unit");
        end
        else
        begin
            $display("FAIL rgb_color_vote_classifier_unit");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/rcvc_pkg.sv
rtl/rcvc_front.sv
rtl/rcvc_queue.sv
rtl/rcvc_back.sv
rtl/rgb_color_vote_classifier_unit.sv
test/tb_top.sv
